>>> rtl/cdsc_pkg.sv
// Shared types, constants and calendar helper functions for the calendar
// date / seconds converter. No dependencies.
`default_nettype none

package cdsc_pkg;

    // field widths
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int TS_W    = 38;
    localparam int EDAY_W  = 21;   // days from year zero to a 12-bit year
    localparam int DOY_W   = 9;    // day of year, 0..365

    // pipeline depth: input register, six work stages, output register
    localparam int NUM_STAGES = 8;

    // item kinds
    localparam logic KIND_D2S = 1'b0;
    localparam logic KIND_S2D = 1'b1;

    // seconds per day is 128 * 675: a shift then a reciprocal divide by 675
    localparam int          SEC_SHIFT     = 7;
    localparam logic [9:0]  SEC_DIV       = 10'd675;
    localparam logic [31:0] DIV675_RECIP  = 32'd3257812230;  // floor(2^41 / 675)
    localparam int          DIV675_SHIFT  = 41;
    // bias that makes the shifted timestamp non-negative, a multiple of 675
    localparam logic [31:0] TS_BIAS       = 32'd1073742075;  // 675 * 1590729
    localparam logic [24:0] TS_BIAS_DAYS  = 25'd1590729;

    // four-year cycle divide
    localparam logic [10:0] CYCLE_DAYS     = 11'd1461;
    localparam logic [21:0] DIV1461_RECIP  = 22'd2939744;    // floor(2^32 / 1461)
    localparam int          DIV1461_SHIFT  = 32;

    localparam logic [37:0] SECS_PER_DAY = 38'd86400;
    localparam logic [11:0] EPOCH_RESET  = 12'd1970;

    // load strobes of the six work stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } t_stage_ld;

    // date to seconds result
    typedef struct packed {
        logic                   ok;
        logic signed [TS_W-1:0] secs;
    } t_d2s_res;

    // seconds to date result
    typedef struct packed {
        logic               ok;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_s2d_res;

    // days before the first of month m, zero for a month code out of range
    function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DOY_W-1:0] base;
        begin
            unique case (m)
                4'd1:    base = 9'd0;
                4'd2:    base = 9'd31;
                4'd3:    base = 9'd59;
                4'd4:    base = 9'd90;
                4'd5:    base = 9'd120;
                4'd6:    base = 9'd151;
                4'd7:    base = 9'd181;
                4'd8:    base = 9'd212;
                4'd9:    base = 9'd243;
                4'd10:   base = 9'd273;
                4'd11:   base = 9'd304;
                4'd12:   base = 9'd334;
                default: base = 9'd0;
            endcase
            cum_days = base + ((leap && m > 4'd2 && m <= 4'd12) ? 9'd1 : 9'd0);
        end
    endfunction

    // days in month m, zero for a month code out of range
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        begin
            unique case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
                4'd2:    month_len = leap ? 5'd29 : 5'd28;
                default: month_len = 5'd0;
            endcase
        end
    endfunction

    // days from January 1 of year zero to January 1 of year y
    function automatic logic [EDAY_W-1:0] days_before_year(input logic [YEAR_W-1:0] y);
        logic [12:0] yp3;
        begin
            yp3 = {1'b0, y} + 13'd3;
            days_before_year = EDAY_W'(EDAY_W'(y) * 21'd365) + EDAY_W'(yp3 >> 2);
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/calendar_date_seconds_converter.sv
// Top level of the calendar date / seconds converter: stream handshake,
// pipeline control, epoch register and output register.
// Depends on cdsc_pkg, cdsc_date2sec and cdsc_sec2date.
//
// Usage:
//   Input words arrive on the s_axis channel; tuser[0] selects the kind:
//   0 turns year/month/day into signed seconds from January 1 midnight of
//   the epoch year, 1 turns a signed timestamp into year/month/day.
//   Results leave on m_axis, one word per input word, in order. tuser[0]
//   carries ok (valid date, or result year within 1..4095).
//   The epoch year is written on the cfg channel (always ready) and resets
//   to 1970. The user must write it only while no word is in flight; the
//   block itself does not enforce this.
//   Throughput: one word per cycle while the receiver is ready; each of the
//   eight pipeline stages takes a new word in the same cycle its current word
//   moves on. Every stage holds its word while the next one is full, so a stalled
//   receiver fills the empty stages first; s_axis_tready drops only when
//   all eight stages hold a word. Reset empties the pipeline.
`default_nettype none

module calendar_date_seconds_converter
    import cdsc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input words
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // year[11:0], month[15:12], day[20:16], timestamp[58:21]
    input  wire  [0:0]  s_axis_tuser,   // kind[0]
    // result words
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_seconds[37:0], out_year[49:38], out_month[53:50], out_day[58:54]
    output logic [0:0]  m_axis_tuser,   // ok[0]
    // epoch year write
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [11:0] i_cfg_data
);

    logic [NUM_STAGES-1:0] go;
    logic [NUM_STAGES-1:0] rdy;
    logic [NUM_STAGES-1:0] ld;
    logic [NUM_STAGES-1:0] n_vld;
    t_stage_ld             stage_ld;
    t_d2s_res              d2s_res;
    t_s2d_res              s2d_res;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] r_kind;
    logic [YEAR_W-1:0]     r_epoch;
    logic [YEAR_W-1:0]     r_s0_year;
    logic [MONTH_W-1:0]    r_s0_month;
    logic [DAY_W-1:0]      r_s0_day;
    logic [TS_W-1:0]       r_s0_ts;
    logic                  r_out_ok;
    logic [TS_W-1:0]       r_out_secs;
    logic [YEAR_W-1:0]     r_out_year;
    logic [MONTH_W-1:0]    r_out_month;
    logic [DAY_W-1:0]      r_out_day;

    // epoch register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= EPOCH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_epoch <= i_cfg_data;
        end
    end

    // per-stage flow: a stage moves on when the next one is empty or moving
    always_comb begin
        go[NUM_STAGES-1]  = r_vld[NUM_STAGES-1] && m_axis_tready;
        rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || go[NUM_STAGES-1];
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            go[k]  = r_vld[k] && rdy[k+1];
            rdy[k] = !r_vld[k] || go[k];
        end
        ld[0] = s_axis_tvalid && rdy[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            ld[k] = go[k-1];
        end
        n_vld = ld | (r_vld & ~go);
    end

    assign stage_ld = '{s1: ld[1], s2: ld[2], s3: ld[3], s4: ld[4], s5: ld[5], s6: ld[6]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // kind travels with each word
    always_ff @(posedge i_clk) begin
        if (ld[0]) r_kind[0] <= s_axis_tuser[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (ld[k]) r_kind[k] <= r_kind[k-1];
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_s0_year  <= s_axis_tdata[11:0];
            r_s0_month <= s_axis_tdata[15:12];
            r_s0_day   <= s_axis_tdata[20:16];
            r_s0_ts    <= s_axis_tdata[58:21];
        end
    end

    cdsc_date2sec u_date2sec (
        .i_clk   (i_clk),
        .i_ld    (stage_ld),
        .i_year  (r_s0_year),
        .i_month (r_s0_month),
        .i_day   (r_s0_day),
        .i_epoch (r_epoch),
        .o_res   (d2s_res)
    );

    cdsc_sec2date u_sec2date (
        .i_clk   (i_clk),
        .i_ld    (stage_ld),
        .i_ts    (r_s0_ts),
        .i_epoch (r_epoch),
        .o_res   (s2d_res)
    );

    // output register, selected by kind
    always_ff @(posedge i_clk) begin
        if (ld[NUM_STAGES-1]) begin
            if (r_kind[NUM_STAGES-2] == KIND_S2D) begin
                r_out_ok    <= s2d_res.ok;
                r_out_secs  <= '0;
                r_out_year  <= s2d_res.year;
                r_out_month <= s2d_res.month;
                r_out_day   <= s2d_res.day;
            end else begin
                r_out_ok    <= d2s_res.ok;
                r_out_secs  <= d2s_res.secs;
                r_out_year  <= '0;
                r_out_month <= '0;
                r_out_day   <= '0;
            end
        end
    end

    assign s_axis_tready   = rdy[0];
    assign m_axis_tvalid   = r_vld[NUM_STAGES-1];
    assign m_axis_tdata    = {5'd0, r_out_day, r_out_month, r_out_year, r_out_secs};
    assign m_axis_tuser[0] = r_out_ok;

    // input stalls only with every stage holding a word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld))
        else $error("input stalled with an empty pipeline stage");

    // a decoded date is always a real month and day
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_kind[NUM_STAGES-1] == KIND_S2D && r_out_ok) |->
        (r_out_month >= 4'd1 && r_out_month <= 4'd12 && r_out_day != 5'd0 &&
         r_out_year != 12'd0 && r_out_secs == '0))
        else $error("seconds to date gave an impossible date");

    // date to seconds leaves the date fields clear, seconds zero when invalid
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_kind[NUM_STAGES-1] == KIND_D2S) |->
        (r_out_year == '0 && r_out_month == '0 && r_out_day == '0 &&
         (r_out_ok || r_out_secs == '0)))
        else $error("date to seconds result has stray fields");

    // reset empties the pipeline
    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> rtl/cdsc_date2sec.sv
// Date to seconds datapath: validates the date, counts days from the epoch
// and scales to seconds. Depends on cdsc_pkg.
`default_nettype none

module cdsc_date2sec
    import cdsc_pkg::*;
(
    input  wire                i_clk,
    input  wire t_stage_ld     i_ld,
    input  wire [YEAR_W-1:0]   i_year,
    input  wire [MONTH_W-1:0]  i_month,
    input  wire [DAY_W-1:0]    i_day,
    input  wire [YEAR_W-1:0]   i_epoch,
    output t_d2s_res           o_res
);

    logic                leap;
    logic [DAY_W-1:0]    mlen;
    logic                date_ok;
    logic [EDAY_W-1:0]   dby_y;
    logic [EDAY_W-1:0]   dby_e;
    logic signed [22:0]  n_s1_d;
    logic signed [40:0]  secs_full;
    t_d2s_res            n_s2;

    logic signed [22:0]  r_s1_d;
    logic                r_s1_ok;
    t_d2s_res            r_s2;
    t_d2s_res            r_s3;
    t_d2s_res            r_s4;
    t_d2s_res            r_s5;
    t_d2s_res            r_s6;

    // stage 1: check month and day, signed day count from the epoch
    always_comb begin
        leap    = (i_year[1:0] == 2'b00);
        mlen    = month_len(i_month, leap);
        date_ok = (i_month >= 4'd1) && (i_month <= 4'd12) &&
                  (i_day != 5'd0) && (i_day <= mlen);
        dby_y   = days_before_year(i_year);
        dby_e   = days_before_year(i_epoch);
        n_s1_d  = $signed({2'b00, dby_y}) + $signed({14'd0, cum_days(i_month, leap)})
                + $signed({18'd0, i_day}) - 23'sd1 - $signed({2'b00, dby_e});
    end

    // stage 2: scale days to seconds
    always_comb begin
        secs_full  = $signed({{18{r_s1_d[22]}}, r_s1_d}) * $signed({3'b000, SECS_PER_DAY});
        n_s2.ok    = r_s1_ok;
        n_s2.secs  = r_s1_ok ? secs_full[TS_W-1:0] : '0;
    end

    // stage registers, later stages only carry the result along
    always_ff @(posedge i_clk) begin
        if (i_ld.s1) begin
            r_s1_d  <= n_s1_d;
            r_s1_ok <= date_ok;
        end
        if (i_ld.s2) r_s2 <= n_s2;
        if (i_ld.s3) r_s3 <= r_s2;
        if (i_ld.s4) r_s4 <= r_s3;
        if (i_ld.s5) r_s5 <= r_s4;
        if (i_ld.s6) r_s6 <= r_s5;
    end

    assign o_res = r_s6;

endmodule

`default_nettype wire

>>> rtl/cdsc_sec2date.sv
// Seconds to date datapath: floor divide by the day length, split into
// four-year cycles, year and month. Depends on cdsc_pkg.
`default_nettype none

module cdsc_sec2date
    import cdsc_pkg::*;
(
    input  wire                i_clk,
    input  wire t_stage_ld     i_ld,
    input  wire [TS_W-1:0]     i_ts,
    input  wire [YEAR_W-1:0]   i_epoch,
    output t_s2d_res           o_res
);

    // stage 1 logic
    logic [32:0]         u_wide;
    logic [31:0]         u;
    logic [63:0]         p1;
    // stage 2 logic
    logic [32:0]         prod1;
    logic [31:0]         rem1_wide;
    // stage 3 logic
    logic [22:0]         q_days;
    logic signed [24:0]  abs_wide;
    // stage 4 logic
    logic [43:0]         p2;
    // stage 5 logic
    logic [22:0]         prod2;
    logic [21:0]         rem2_wide;
    // stage 6 logic
    logic                corr;
    logic [YEAR_W-1:0]   qh;
    logic [10:0]         rc;
    logic [1:0]          yoff;
    logic [DOY_W-1:0]    doy;
    logic [13:0]         y_full;
    // month search
    logic [MONTH_W-1:0]  mcnt;
    logic [MONTH_W-1:0]  mon;
    logic [DOY_W-1:0]    dom;

    logic [31:0]         r_s1_u;
    logic [22:0]         r_s1_q0;
    logic [22:0]         r_s2_q0;
    logic [10:0]         r_s2_r0;
    logic [21:0]         r_s3_abs;
    logic                r_s3_neg;
    logic [21:0]         r_s4_abs;
    logic [YEAR_W-1:0]   r_s4_qh0;
    logic                r_s4_neg;
    logic [YEAR_W-1:0]   r_s5_qh0;
    logic [11:0]         r_s5_rr0;
    logic                r_s5_neg;
    logic [YEAR_W-1:0]   r_s6_y;
    logic [DOY_W-1:0]    r_s6_doy;
    logic                r_s6_leap;
    logic                r_s6_ok;

    // stage 1: drop the low 7 bits (floor), bias positive, reciprocal of 675
    always_comb begin
        u_wide = {{2{i_ts[TS_W-1]}}, i_ts[TS_W-1:SEC_SHIFT]} + {1'b0, TS_BIAS};
        u      = u_wide[31:0];
        p1     = {32'd0, u} * {32'd0, DIV675_RECIP};
    end

    // stage 2: remainder of the estimate, below twice the divisor
    always_comb begin
        prod1     = {10'd0, r_s1_q0} * {23'd0, SEC_DIV};
        rem1_wide = r_s1_u - prod1[31:0];
    end

    // stage 3: corrected day count, remove bias, add epoch days
    always_comb begin
        q_days   = r_s2_q0 + ((r_s2_r0 >= {1'b0, SEC_DIV}) ? 23'd1 : 23'd0);
        abs_wide = $signed({2'b00, q_days}) - $signed(TS_BIAS_DAYS)
                 + $signed({4'd0, days_before_year(i_epoch)});
    end

    // stage 4: reciprocal estimate of the four-year cycle count
    always_comb begin
        p2 = {22'd0, r_s3_abs} * {22'd0, DIV1461_RECIP};
    end

    // stage 5: remainder of the cycle estimate
    always_comb begin
        prod2     = {11'd0, r_s4_qh0} * {12'd0, CYCLE_DAYS};
        rem2_wide = r_s4_abs - prod2[21:0];
    end

    // stage 6: correct the cycle split, year within cycle, range check
    always_comb begin
        corr = (r_s5_rr0 >= {1'b0, CYCLE_DAYS});
        qh   = r_s5_qh0 + (corr ? 12'd1 : 12'd0);
        rc   = corr ? 11'(r_s5_rr0 - {1'b0, CYCLE_DAYS}) : r_s5_rr0[10:0];
        if (rc < 11'd366) begin
            yoff = 2'd0;
            doy  = rc[DOY_W-1:0];
        end else if (rc < 11'd731) begin
            yoff = 2'd1;
            doy  = DOY_W'(rc - 11'd366);
        end else if (rc < 11'd1096) begin
            yoff = 2'd2;
            doy  = DOY_W'(rc - 11'd731);
        end else begin
            yoff = 2'd3;
            doy  = DOY_W'(rc - 11'd1096);
        end
        y_full = {qh, 2'b00} + {12'd0, yoff};
    end

    // output: month by counting month ends passed, then day of month
    always_comb begin
        mcnt = '0;
        for (int k = 1; k <= 11; k++) begin
            if (r_s6_doy >= cum_days(MONTH_W'(k + 1), r_s6_leap))
                mcnt = mcnt + 4'd1;
        end
        mon = mcnt + 4'd1;
        dom = r_s6_doy - cum_days(mon, r_s6_leap) + 9'd1;
        o_res.ok    = r_s6_ok;
        o_res.year  = r_s6_ok ? r_s6_y : '0;
        o_res.month = r_s6_ok ? mon : '0;
        o_res.day   = r_s6_ok ? dom[DAY_W-1:0] : '0;
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_ld.s1) begin
            r_s1_u  <= u;
            r_s1_q0 <= p1[63:DIV675_SHIFT];
        end
        if (i_ld.s2) begin
            r_s2_q0 <= r_s1_q0;
            r_s2_r0 <= rem1_wide[10:0];
        end
        if (i_ld.s3) begin
            r_s3_abs <= abs_wide[21:0];
            r_s3_neg <= abs_wide[24];
        end
        if (i_ld.s4) begin
            r_s4_abs <= r_s3_abs;
            r_s4_qh0 <= p2[DIV1461_SHIFT+YEAR_W-1:DIV1461_SHIFT];
            r_s4_neg <= r_s3_neg;
        end
        if (i_ld.s5) begin
            r_s5_qh0 <= r_s4_qh0;
            r_s5_rr0 <= rem2_wide[11:0];
            r_s5_neg <= r_s4_neg;
        end
        if (i_ld.s6) begin
            r_s6_y    <= y_full[YEAR_W-1:0];
            r_s6_doy  <= doy;
            r_s6_leap <= (yoff == 2'd0);
            r_s6_ok   <= !r_s5_neg && (y_full != 14'd0) && (y_full <= 14'd4095);
        end
    end

endmodule

`default_nettype wire
